### rtl/dq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue: beat payloads,
// action and status codes, controller states and control bundles.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DQ_DEPTH = 16;
    localparam int DATA_W   = 32;
    localparam int OCC_W    = 5;

    typedef enum logic [1:0] {
        ACT_PUSH_BACK  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_BACK   = 2'd3
    } dq_action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

    typedef struct packed {
        dq_action_t                action;
        logic signed [DATA_W-1:0]  push_value;
    } dq_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  pop_value;
        dq_status_t                status;
        logic        [OCC_W-1:0]   occupancy;
    } dq_out_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_READ = 2'd1,
        S_RESP = 2'd2
    } dq_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // execute the beat on the input port
        logic capture;  // load read data into the result register
    } dq_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pop_read; // current input beat is a pop that reads the ring
    } dq_stat_t;

endpackage : dq_pkg
`default_nettype wire

### rtl/dq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Ring storage, front index, stored count and the result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dq_pkg::dq_in_t  in_data,
    input  wire dq_pkg::dq_cmd_t cmd,
    output dq_pkg::dq_stat_t     stat,
    output dq_pkg::dq_out_t      out_data
);
    import dq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_W-1:0] entries_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    dq_out_t       out_reg;

    logic          full, empty;
    logic [PW-1:0] front_dec, front_inc, back_slot, tail_slot, slot;
    logic [CW-1:0] count_m1;
    logic          wr_hit, rd_hit;
    dq_status_t    st;

    function automatic logic [PW-1:0] wrap_add(input logic [PW:0] s);
        if (s >= DEPTH_W)
            return PW'(s - DEPTH_W);
        else
            return PW'(s);
    endfunction

    always_comb
    begin
        full      = (count_reg == FULL_CNT);
        empty     = (count_reg == '0);
        count_m1  = count_reg - CW'(1);
        front_dec = (front_reg == '0) ? LAST_IDX : front_reg - PW'(1);
        front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + PW'(1);
        back_slot = wrap_add((PW + 1)'(front_reg) + (PW + 1)'(count_reg));
        tail_slot = wrap_add((PW + 1)'(front_reg) + (PW + 1)'(count_m1));

        front_next = front_reg;
        count_next = count_reg;
        slot       = front_reg;
        wr_hit     = 1'b0;
        rd_hit     = 1'b0;
        st         = ST_OK;

        unique case (in_data.action)
            ACT_PUSH_BACK:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    slot       = back_slot;
                    wr_hit     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_PUSH_FRONT:
            begin
                if (full)
                    st = ST_FULL;
                else
                begin
                    slot       = front_dec;
                    front_next = front_dec;
                    wr_hit     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            ACT_POP_FRONT:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    slot       = front_reg;
                    front_next = front_inc;
                    rd_hit     = 1'b1;
                    count_next = count_m1;
                end
            end
            ACT_POP_BACK:
            begin
                if (empty)
                    st = ST_EMPTY;
                else
                begin
                    slot       = tail_slot;
                    rd_hit     = 1'b1;
                    count_next = count_m1;
                end
            end
        endcase

        stat.pop_read = rd_hit;
    end

    // Pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Ring storage, one access per beat, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_hit)
            entries_mem[slot] <= in_data.push_value;
        if (cmd.accept && rd_hit)
            rd_data_reg <= entries_mem[slot];
    end

    // Result register: zero value until a pop fills it
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            out_reg.pop_value <= '0;
            out_reg.status    <= st;
            out_reg.occupancy <= OCC_W'(count_next);
        end
        else if (cmd.capture)
            out_reg.pop_value <= rd_data_reg;
    end

    assign out_data = out_reg;

endmodule : dq_datapath
`default_nettype wire

### rtl/dq_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_controller
// Sequencer: accept a beat, wait for ring read data on a pop, present result.
// ----------------------------------------------------------------------------
module dq_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire dq_pkg::dq_stat_t stat,
    output dq_pkg::dq_cmd_t       cmd
);
    import dq_pkg::*;

    dq_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.accept  = 1'b0;
        cmd.capture = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                    state_next = stat.pop_read ? S_READ : S_RESP;
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule : dq_controller
`default_nettype wire

### rtl/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Result: for a push or an error, status and occupancy are registered when the
//         beat is accepted; for a successful pop the ring read is registered
//         first, then loaded into the result register (S_READ, then S_RESP).
// Flow: the sequencer holds one beat in flight until its result beat is taken,
//       so no new beat is accepted before then; an output stall holds it off.
// Reset: rst_n asynchronous, clears front index, count and controller state;
//        ring contents are undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a ring of DEPTH entries.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire dq_pkg::dq_in_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output dq_pkg::dq_out_t      out_data
);
    import dq_pkg::*;

    // Command and status bundles between sequencer and datapath
    dq_cmd_t  cmd;
    dq_stat_t stat;

    // Sequencer: take one beat, hold it until its result beat is taken
    dq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Ring, pointers and result register
    dq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

    // One beat at a time: after an accept, hold off the next beat
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while a beat is still in flight");

    // Never take a new beat while a result is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> !out_valid)
        else $error("input accepted while result pending");

    // A full refusal only happens with the ring full
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_FULL) |->
            (out_data.occupancy == OCC_W'(DEPTH)))
        else $error("full status with wrong occupancy");

    // An empty pop leaves nothing stored and returns zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_EMPTY) |->
            (out_data.occupancy == '0 && out_data.pop_value == '0))
        else $error("empty status with non-zero value or occupancy");

endmodule : double_ended_queue
`default_nettype wire
